@@ hdl/u8d_pkg.sv @@
// Shared types and constants for the UTF-8 to code point decoder.
// No dependencies; every other file refers to it by scoped names.

package u8d_pkg;

    localparam int CP_W        = 31;
    localparam int LEN_W       = 3;
    localparam int QUEUE_DEPTH = 2;

    // configuration register map (byte addresses)
    localparam int        PADDR_W               = 3;
    localparam logic [2:0] ADDR_NUL_TERMINATED  = 3'd0;

    // lead length code for a byte that cannot start a sequence
    localparam logic [LEN_W-1:0] LEN_INVALID = 3'd0;
    localparam logic [LEN_W-1:0] LEN_ONE     = 3'd1;

    typedef enum logic [1:0] {
        ST_CHAR    = 2'd0,
        ST_END     = 2'd1,
        ST_INVALID = 2'd2
    } status_t;

    // classified word handed from the front to the back
    typedef struct packed {
        logic             nul_end;   // NUL that ends text
        logic [LEN_W-1:0] lead_len;  // length if taken as a lead byte
        logic [6:0]       payload;   // lead payload bits
        logic [5:0]       low6;      // continuation payload bits
        logic             last;
    } entry_t;

    function automatic entry_t classify(input logic [7:0] b, input logic last,
                                        input logic nul_mode);
        entry_t e;
        e.nul_end = nul_mode && (b == 8'h00);
        e.low6    = b[5:0];
        e.last    = last;
        e.payload = 7'h00;
        if (b[7] == 1'b0)
        begin
            e.lead_len = 3'd1;
            e.payload  = b[6:0];
        end
        else if ((b & 8'hE0) == 8'hC0)
        begin
            e.lead_len = 3'd2;
            e.payload  = {2'b00, b[4:0]};
        end
        else if ((b & 8'hF0) == 8'hE0)
        begin
            e.lead_len = 3'd3;
            e.payload  = {3'b000, b[3:0]};
        end
        else if ((b & 8'hF8) == 8'hF0)
        begin
            e.lead_len = 3'd4;
            e.payload  = {4'h0, b[2:0]};
        end
        else if ((b & 8'hFC) == 8'hF8)
        begin
            e.lead_len = 3'd5;
            e.payload  = {5'h00, b[1:0]};
        end
        else if ((b & 8'hFE) == 8'hFC)
        begin
            e.lead_len = 3'd6;
            e.payload  = {6'h00, b[0]};
        end
        else
        begin
            e.lead_len = LEN_INVALID;
        end
        return e;
    endfunction

endpackage

@@ hdl/u8d_if.sv @@
// Valid/ready channel interfaces for text bytes in and code points out.
// Depends on u8d_pkg for field widths.

interface u8d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface u8d_cp_if;
    logic                            valid;
    logic                            ready;
    logic [u8d_pkg::CP_W-1:0]        code_point;
    logic [u8d_pkg::LEN_W-1:0]       seq_length;
    logic [1:0]                      status;

    modport source (output valid, output code_point, output seq_length, output status,
                    input ready);
    modport sink   (input valid, input code_point, input seq_length, input status,
                    output ready);
endinterface

@@ hdl/u8d_cfg.sv @@
// APB-style configuration register block (nul_terminated).
// Depends on u8d_pkg for the register map.

module u8d_cfg
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [u8d_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output logic                        nul_mode
);

    logic nul_mode_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == u8d_pkg::ADDR_NUL_TERMINATED);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nul_mode_reg <= 1'b1;
        end
        else if (wr_en)
        begin
            nul_mode_reg <= pwdata[0];
        end
    end

    assign prdata   = (paddr == u8d_pkg::ADDR_NUL_TERMINATED) ? {31'd0, nul_mode_reg} : 32'd0;
    assign nul_mode = nul_mode_reg;

endmodule

@@ hdl/u8d_front.sv @@
// Front stage: takes text bytes, classifies them and pushes words to the queue.
// Depends on u8d_pkg and u8d_if.

module u8d_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              nul_mode,
    u8d_byte_if.sink          text,
    output u8d_pkg::entry_t   push_data,
    output logic              push,
    input  logic              full
);

    logic            stage_valid_reg;
    logic            stage_valid_next;
    u8d_pkg::entry_t stage_reg;
    logic            take;

    assign push       = stage_valid_reg && !full;
    assign push_data  = stage_reg;
    assign text.ready = !stage_valid_reg || !full;
    assign take       = text.valid && text.ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (take)
        begin
            stage_valid_next = 1'b1;
        end
        else if (push)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_reg <= u8d_pkg::classify(text.in_byte, text.last_byte, nul_mode);
        end
    end

endmodule

@@ hdl/u8d_queue.sv @@
// Short queue of classified words between the front and back stages.
// Depends on u8d_pkg for the word type.

module u8d_queue
#(
    parameter int Depth = u8d_pkg::QUEUE_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  u8d_pkg::entry_t push_data,
    output logic            full,
    input  logic            pop,
    output u8d_pkg::entry_t pop_data,
    output logic            not_empty
);

    localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CNT_W = $clog2(Depth + 1);

    u8d_pkg::entry_t  mem [Depth];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(Depth));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hdl/u8d_back.sv @@
// Back stage: sequence state, accumulator and the output register.
// Depends on u8d_pkg and u8d_if.

module u8d_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            not_empty,
    input  u8d_pkg::entry_t entry,
    output logic            pop,
    u8d_cp_if.source        chars
);

    localparam int CP_W  = u8d_pkg::CP_W;
    localparam int LEN_W = u8d_pkg::LEN_W;

    logic [CP_W-1:0]  partial_reg;
    logic [CP_W-1:0]  partial_next;
    logic [LEN_W-1:0] bytes_left_reg;
    logic [LEN_W-1:0] bytes_left_next;
    logic [LEN_W-1:0] seq_len_reg;
    logic [LEN_W-1:0] seq_len_next;
    logic             draining_reg;
    logic             draining_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [CP_W-1:0]  cp_reg;
    logic [LEN_W-1:0] len_reg;
    u8d_pkg::status_t status_reg;

    logic             emit;
    logic [CP_W-1:0]  emit_cp;
    logic [LEN_W-1:0] emit_len;
    u8d_pkg::status_t emit_status;
    logic [CP_W-1:0]  shifted;

    assign pop     = not_empty && (!out_valid_reg || chars.ready);
    assign shifted = {partial_reg[CP_W-7:0], entry.low6};

    always_comb
    begin
        partial_next    = partial_reg;
        bytes_left_next = bytes_left_reg;
        seq_len_next    = seq_len_reg;
        draining_next   = draining_reg;
        emit            = 1'b0;
        emit_cp         = '0;
        emit_len        = '0;
        emit_status     = u8d_pkg::ST_CHAR;
        if (pop)
        begin
            if (draining_reg)
            begin
                if (entry.last)
                begin
                    draining_next = 1'b0;
                end
            end
            else if (entry.nul_end)
            begin
                emit            = 1'b1;
                emit_status     = u8d_pkg::ST_END;
                bytes_left_next = '0;
                seq_len_next    = '0;
                draining_next   = !entry.last;
            end
            else if (bytes_left_reg != '0)
            begin
                partial_next    = shifted;
                bytes_left_next = bytes_left_reg - 1'b1;
                if (bytes_left_reg == LEN_W'(1))
                begin
                    emit         = 1'b1;
                    emit_cp      = shifted;
                    emit_len     = seq_len_reg;
                    seq_len_next = '0;
                end
                else if (entry.last)
                begin
                    // cut short by the end of the string
                    emit            = 1'b1;
                    emit_status     = u8d_pkg::ST_END;
                    bytes_left_next = '0;
                    seq_len_next    = '0;
                end
            end
            else if (entry.lead_len == u8d_pkg::LEN_INVALID)
            begin
                emit          = 1'b1;
                emit_status   = u8d_pkg::ST_INVALID;
                seq_len_next  = '0;
                draining_next = !entry.last;
            end
            else if (entry.lead_len == u8d_pkg::LEN_ONE)
            begin
                emit     = 1'b1;
                emit_cp  = CP_W'(entry.payload);
                emit_len = u8d_pkg::LEN_ONE;
            end
            else if (entry.last)
            begin
                emit        = 1'b1;
                emit_status = u8d_pkg::ST_END;
            end
            else
            begin
                partial_next    = CP_W'(entry.payload);
                seq_len_next    = entry.lead_len;
                bytes_left_next = entry.lead_len - 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (chars.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= '0;
            seq_len_reg    <= '0;
            draining_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            bytes_left_reg <= bytes_left_next;
            seq_len_reg    <= seq_len_next;
            draining_reg   <= draining_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        partial_reg <= partial_next;
        if (emit)
        begin
            cp_reg     <= emit_cp;
            len_reg    <= emit_len;
            status_reg <= emit_status;
        end
    end

    assign chars.valid      = out_valid_reg;
    assign chars.code_point = cp_reg;
    assign chars.seq_length = len_reg;
    assign chars.status     = status_reg;

endmodule

@@ hdl/utf8_to_codepoint_decoder_top.sv @@
// UTF-8 decoder (legacy 1 to 6 byte forms, up to 31-bit code points). One byte
// is taken per cycle, back to back, unless a full queue holds the front stage;
// the byte that completes a result word passes through a classify register, a
// small word queue, and the output register of the sequence stage. Steady
// throughput is one byte per cycle, set by the sequence stage, which retires one
// queued word a cycle while its output register is free or being taken. Bytes
// that cause no result still pass through that stage. nul_terminated must be
// written over APB at address 0 while the decoder is idle; this is unchecked.
// Depends on u8d_pkg, u8d_if, u8d_cfg, u8d_front, u8d_queue and u8d_back.

module utf8_to_codepoint_decoder_top
#(
    parameter int QueueDepth = u8d_pkg::QUEUE_DEPTH
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [u8d_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    u8d_byte_if.sink                    text,
    u8d_cp_if.source                    chars
);

    logic            nul_mode;
    logic            push;
    logic            full;
    logic            pop;
    logic            not_empty;
    u8d_pkg::entry_t push_data;
    u8d_pkg::entry_t pop_data;

    u8d_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .nul_mode (nul_mode)
    );

    u8d_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .nul_mode  (nul_mode),
        .text      (text),
        .push_data (push_data),
        .push      (push),
        .full      (full)
    );

    u8d_queue #(.Depth(QueueDepth)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .not_empty (not_empty)
    );

    u8d_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .entry     (pop_data),
        .pop       (pop),
        .chars     (chars)
    );

endmodule

@@ tb/sv/utf8_to_codepoint_decoder_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for utf8_to_codepoint_decoder_top: random and directed
// byte strings in, decoded code point words checked against an in-line decoder.
// Depends on u8d_pkg, u8d_if and the decoder RTL.

module utf8_to_codepoint_decoder_top_tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_TICKS = 12;
    localparam int PHASE_BYTES  = 320;
    localparam int CALM_FROM    = 500;
    localparam int CALM_TO      = 850;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } text_word_t;

    typedef struct packed {
        logic [u8d_pkg::CP_W-1:0]  cp;
        logic [u8d_pkg::LEN_W-1:0] len;
        u8d_pkg::status_t          st;
    } char_word_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [u8d_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0]                 pwdata = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    u8d_byte_if text_bus();
    u8d_cp_if   chars_bus();

    utf8_to_codepoint_decoder_top u_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .text    (text_bus),
        .chars   (chars_bus)
    );

    text_word_t  byte_q[$];
    char_word_t  pending_chars[$];
    text_word_t  next_word;
    char_word_t  got_word;

    // decoder mirror
    logic                     nul_mode = 1'b1;
    logic [u8d_pkg::CP_W-1:0] acc_value = '0;
    logic [2:0]               left_cnt = '0;
    logic [2:0]               char_len = '0;
    logic                     dropping = 1'b0;

    int  sent_bytes = 0;
    int  cycle_cnt  = 0;
    int  err_cnt    = 0;
    logic calm;

    // long stretch with no idling on either side
    assign calm = (sent_bytes >= CALM_FROM) && (sent_bytes < CALM_TO);

    initial
    begin
        text_bus.valid     = 1'b0;
        text_bus.in_byte   = 8'h00;
        text_bus.last_byte = 1'b0;
        chars_bus.ready    = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void expect_char(logic [u8d_pkg::CP_W-1:0] cp,
                                        logic [u8d_pkg::LEN_W-1:0] len,
                                        u8d_pkg::status_t st);
        char_word_t w;
        w.cp  = cp;
        w.len = len;
        w.st  = st;
        pending_chars.push_back(w);
    endfunction

    // end of text or bad lead: drop the sequence, drain unless this was the last word
    function automatic void abort_text(u8d_pkg::status_t st, logic last);
        acc_value = '0;
        left_cnt  = '0;
        char_len  = '0;
        dropping  = !last;
        expect_char('0, '0, st);
    endfunction

    function automatic void decode_byte(logic [7:0] b, logic last);
        logic [2:0] len;
        logic [6:0] payload;
        if (dropping)
        begin
            if (last)
                dropping = 1'b0;
            return;
        end
        if (nul_mode && b == 8'h00)
        begin
            abort_text(u8d_pkg::ST_END, last);
            return;
        end
        if (left_cnt != 0)
        begin
            acc_value = {acc_value[u8d_pkg::CP_W-7:0], b[5:0]};
            left_cnt  = left_cnt - 3'd1;
            if (left_cnt == 0)
            begin
                expect_char(acc_value, char_len, u8d_pkg::ST_CHAR);
                acc_value = '0;
                char_len  = '0;
            end
            else if (last)
                abort_text(u8d_pkg::ST_END, 1'b1);
            return;
        end
        casez (b)
            8'b0???????:
            begin
                expect_char(u8d_pkg::CP_W'(b), 3'd1, u8d_pkg::ST_CHAR);
                return;
            end
            8'b110?????: begin len = 3'd2; payload = {2'b00, b[4:0]}; end
            8'b1110????: begin len = 3'd3; payload = {3'b000, b[3:0]}; end
            8'b11110???: begin len = 3'd4; payload = {4'h0, b[2:0]}; end
            8'b111110??: begin len = 3'd5; payload = {5'h00, b[1:0]}; end
            8'b1111110?: begin len = 3'd6; payload = {6'h00, b[0]}; end
            default:
            begin
                abort_text(u8d_pkg::ST_INVALID, last);
                return;
            end
        endcase
        if (last)
        begin
            abort_text(u8d_pkg::ST_END, 1'b1);
            return;
        end
        acc_value = u8d_pkg::CP_W'(payload);
        char_len  = len;
        left_cnt  = len - 3'd1;
    endfunction

    // byte driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            text_bus.valid     <= 1'b0;
            text_bus.in_byte   <= 8'h00;
            text_bus.last_byte <= 1'b0;
        end
        else
        begin
            if (text_bus.valid && text_bus.ready)
            begin
                decode_byte(text_bus.in_byte, text_bus.last_byte);
                sent_bytes <= sent_bytes + 1;
            end
            if (!text_bus.valid || text_bus.ready)
            begin
                if (byte_q.size() != 0 && (calm || $urandom_range(99) >= 10))
                begin
                    next_word = byte_q.pop_front();
                    text_bus.valid     <= 1'b1;
                    text_bus.in_byte   <= next_word.data;
                    text_bus.last_byte <= next_word.last;
                end
                else
                    text_bus.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (!rst_n)
            chars_bus.ready <= 1'b0;
        else
        begin
            if (chars_bus.valid && chars_bus.ready)
            begin
                if (pending_chars.size() == 0)
                begin
                    $display("%0t: unexpected word cp=%h len=%0d status=%0d", $time,
                             chars_bus.code_point, chars_bus.seq_length, chars_bus.status);
                    err_cnt++;
                end
                else
                begin
                    got_word = pending_chars.pop_front();
                    if (chars_bus.code_point !== got_word.cp)
                    begin
                        $display("%0t: code_point expected %h actual %h", $time,
                                 got_word.cp, chars_bus.code_point);
                        err_cnt++;
                    end
                    if (chars_bus.seq_length !== got_word.len)
                    begin
                        $display("%0t: seq_length expected %0d actual %0d", $time,
                                 got_word.len, chars_bus.seq_length);
                        err_cnt++;
                    end
                    if (chars_bus.status !== got_word.st)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 got_word.st, chars_bus.status);
                        err_cnt++;
                    end
                end
            end
            chars_bus.ready <= calm || ($urandom_range(99) >= 10);
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic push_byte(logic [7:0] b, logic last);
        text_word_t w;
        w.data = b;
        w.last = last;
        byte_q.push_back(w);
    endtask

    task automatic apb_write(logic [u8d_pkg::PADDR_W-1:0] addr, logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == u8d_pkg::ADDR_NUL_TERMINATED)
            nul_mode = data[0];
    endtask

    // waits until every word has gone through and the pipeline has emptied
    task automatic wait_drained();
        while (byte_q.size() != 0 || text_bus.valid || pending_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    function automatic logic [7:0] lead_byte(int len);
        logic [7:0] r;
        r = 8'($urandom);
        case (len)
            1:       return {1'b0, r[6:0]};
            2:       return {3'b110, r[4:0]};
            3:       return {4'b1110, r[3:0]};
            4:       return {5'b11110, r[2:0]};
            5:       return {6'b111110, r[1:0]};
            default: return {7'b1111110, r[0]};
        endcase
    endfunction

    function automatic logic [7:0] cont_byte();
        // continuation bytes are not checked, so now and then send anything
        if ($urandom_range(99) < 8)
            return 8'($urandom);
        return {2'b10, 6'($urandom)};
    endfunction

    function automatic logic [7:0] bad_lead();
        case ($urandom_range(3))
            0:       return 8'hFE;
            1:       return 8'hFF;
            default: return {2'b10, 6'($urandom)};
        endcase
    endfunction

    function automatic int char_size();
        return ($urandom_range(99) < 35) ? 1 : $urandom_range(6, 2);
    endfunction

    task automatic queue_char(int len, logic last_here);
        push_byte(lead_byte(len), last_here && len == 1);
        for (int i = 1; i < len; i++)
            push_byte(cont_byte(), last_here && i == len - 1);
    endtask

    task automatic queue_text(int budget);
        int added;
        int nchars;
        int len;
        int cut;
        int k;
        added = 0;
        while (added < budget)
        begin
            k = byte_q.size();
            case ($urandom_range(99)) inside
                [0:69]:
                begin
                    // well-formed string
                    nchars = $urandom_range(8, 1);
                    for (int c = 0; c < nchars; c++)
                        queue_char(char_size(), c == nchars - 1);
                end
                [70:79]:
                begin
                    // cut short by the last word
                    if ($urandom_range(1))
                        queue_char(char_size(), 1'b0);
                    len = $urandom_range(6, 2);
                    cut = $urandom_range(len - 2);
                    push_byte(lead_byte(len), cut == 0);
                    for (int i = 1; i <= cut; i++)
                        push_byte(cont_byte(), i == cut);
                end
                [80:87]:
                begin
                    // bad lead then a tail that gets dropped
                    if ($urandom_range(1))
                        queue_char(char_size(), 1'b0);
                    cut = $urandom_range(3);
                    push_byte(bad_lead(), cut == 0);
                    for (int i = 1; i <= cut; i++)
                        push_byte(8'($urandom), i == cut);
                end
                [88:93]:
                begin
                    // NUL as a lead or inside a sequence
                    len = $urandom_range(6, 1);
                    cut = $urandom_range(len - 1);
                    if (cut == 0)
                        push_byte(8'h00, 1'b0);
                    else
                    begin
                        push_byte(lead_byte(len), 1'b0);
                        for (int i = 1; i < cut; i++)
                            push_byte(cont_byte(), 1'b0);
                        push_byte(8'h00, 1'b0);
                    end
                    cut = $urandom_range(3);
                    for (int i = 0; i <= cut; i++)
                        push_byte(8'($urandom), i == cut);
                end
                default:
                begin
                    // noise
                    cut = $urandom_range(6, 1);
                    for (int i = 0; i < cut; i++)
                        push_byte(8'($urandom), $urandom_range(99) < 20);
                    push_byte(8'($urandom), 1'b1);
                end
            endcase
            added += byte_q.size() - k;
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // NUL-terminated mode straight out of reset
        push_byte(8'h00, 1'b0);          // NUL lead ends text, then drain
        push_byte(8'h41, 1'b1);
        push_byte(8'h41, 1'b0);
        push_byte(8'h7F, 1'b0);
        push_byte(8'hC0, 1'b0);          // overlong zero
        push_byte(8'h80, 1'b0);
        push_byte(8'hDF, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hE2, 1'b0);          // NUL inside a sequence
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h80, 1'b1);          // stray continuation as lead, last word
        push_byte(8'hFE, 1'b0);          // bad lead, drain
        push_byte(8'h12, 1'b1);
        push_byte(8'hF0, 1'b0);          // cut short on a continuation
        push_byte(8'h9F, 1'b1);
        push_byte(8'hC3, 1'b1);          // cut short on the lead
        push_byte(8'hFD, 1'b0);          // largest 31-bit value, last completes it
        for (int i = 0; i < 5; i++)
            push_byte(8'hBF, i == 4);
        wait_drained();

        apb_write(u8d_pkg::ADDR_NUL_TERMINATED, 32'd0);
        push_byte(8'h00, 1'b0);          // NUL is a plain character
        push_byte(8'hC2, 1'b0);          // NUL continuation adds zero bits
        push_byte(8'h00, 1'b1);
        push_byte(8'hFC, 1'b0);
        for (int i = 0; i < 5; i++)
            push_byte(8'h80, i == 4);
        queue_text(PHASE_BYTES);
        wait_drained();

        apb_write(u8d_pkg::ADDR_NUL_TERMINATED, 32'd1);
        queue_text(PHASE_BYTES);
        wait_drained();

        apb_write(u8d_pkg::ADDR_NUL_TERMINATED, 32'd0);
        queue_text(PHASE_BYTES);
        wait_drained();

        apb_write(u8d_pkg::ADDR_NUL_TERMINATED, 32'd1);
        queue_text(PHASE_BYTES);
        wait_drained();

        if (err_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
